FILE: sv/aau_pkg.sv
`default_nettype none

package aau_pkg;

    localparam logic [2:0] OP_GELU = 3'd0;
    localparam logic [2:0] OP_ERF  = 3'd1;
    localparam logic [2:0] OP_TANH = 3'd2;
    localparam logic [2:0] OP_SIGM = 3'd3;
    localparam logic [2:0] OP_MAX  = 3'd4;

    localparam logic signed [15:0] G1    = 16'sd20115;
    localparam logic signed [17:0] G2    = 18'sd32834;
    localparam logic signed [17:0] GMAX  = 18'sd65667;
    localparam logic signed [17:0] GK    = 18'sd65387;
    localparam logic signed [15:0] GB    = -16'sd262;

    localparam logic signed [18:0] EK    = 19'sd72534;
    localparam logic signed [15:0] E3    = 16'sd2248;
    localparam logic [15:0]        EB2   = 16'd24778;
    localparam logic [17:0]        EB0   = 18'd65208;
    localparam logic signed [31:0] ELIM  = 32'sd131072;

    localparam logic signed [18:0] TK    = 19'sd58984;
    localparam logic signed [15:0] T3    = 16'sd3515;
    localparam logic [15:0]        TB2   = 16'd22488;
    localparam logic [17:0]        TB0   = 18'd59062;
    localparam logic signed [31:0] TLIM  = 32'sd196608;

    localparam logic signed [20:0] HALF  = 21'sd32768;

    localparam int DIV_STAGES = 6;
    localparam int DIV_BITS   = 3;
    localparam int QUO_W      = DIV_STAGES * DIV_BITS;

    typedef struct packed {
        logic [18:0] rem;
        logic [2:0]  quo;
    } t_div_res;

    function automatic logic signed [63:0] trunc16(input logic signed [63:0] v);
        logic signed [63:0] t;
        t = v + (v[63] ? 64'sd65535 : 64'sd0);
        return t >>> 16;
    endfunction

    function automatic t_div_res div_step(input logic [18:0] rem, input logic [2:0] bits,
                                          input logic [18:0] den);
        t_div_res   res;
        logic [19:0] t;
        logic [18:0] r;
        r = rem;
        res.quo = 3'b000;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {r, bits[DIV_BITS-1-i]};
            if (t >= {1'b0, den}) begin
                t = t - {1'b0, den};
                res.quo[DIV_BITS-1-i] = 1'b1;
            end
            r = t[18:0];
        end
        res.rem = r;
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: sv/approx_activation_unit_core.sv
`default_nettype none

// Approximate activation unit on signed Q16.16: GELU (hard-sigmoid gate), erf, tanh,
// sigmoid and a two-input max, chosen per transaction by the operation code; codes 5 to 7
// give zero. Fully pipelined, 13 register stages from accept to result: four multiply
// stages, a numerator and saturation stage, a six-stage restoring divider retiring three
// quotient bits per stage, one gain multiply and the output register. One transaction may
// enter every cycle; each stage holds independently, so a stalled output fills bubbles
// before holding the input.

module approx_activation_unit_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_ready,
    input  wire  [2:0]  i_operation,
    input  wire  [31:0] i_operand_a,
    input  wire  [31:0] i_operand_b,
    output logic        o_valid,
    input  wire         i_ready,
    output logic [31:0] o_result_value
);

    localparam int NSTG = 13;
    localparam int DIV0 = 5;

    logic [NSTG:1] r_vld;
    logic [NSTG:1] en;

    logic [2:0]         r_op  [1:NSTG];
    logic signed [31:0] r_ear [1:NSTG];

    logic signed [31:0] r_a1, r_a2;
    logic signed [18:0] r_y1, r_y2, r_y3, r_y4;
    logic signed [47:0] r_gm1;
    logic signed [17:0] r_g2;
    logic signed [37:0] r_y2p2;
    logic signed [49:0] r_tp3;
    logic signed [39:0] r_y3p3;
    logic [35:0]        r_dp3;
    logic signed [51:0] r_gkp4;
    logic signed [37:0] r_c3p4;
    logic [18:0]        r_den4;

    logic [18:0]                 r_rem [0:aau_pkg::DIV_STAGES];
    logic [17:0]                 r_low [0:aau_pkg::DIV_STAGES];
    logic [aau_pkg::QUO_W-1:0]   r_quo [0:aau_pkg::DIV_STAGES];
    logic [18:0]                 r_den [0:aau_pkg::DIV_STAGES];
    logic                        r_sgn [0:aau_pkg::DIV_STAGES];
    logic signed [37:0] r_kp;
    logic signed [31:0] r_res;

    always_comb begin
        en[NSTG] = !r_vld[NSTG] || i_ready;
        for (int k = NSTG - 1; k >= 1; k--) begin
            en[k] = !r_vld[k] || en[k+1];
        end
    end

    assign o_ready        = en[1];
    assign o_valid        = r_vld[NSTG];
    assign o_result_value = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (en[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= NSTG; k++) begin
                if (en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    logic signed [31:0] a_in, b_in, x_half, xs, lim;
    logic signed [31:0] n_y;
    logic signed [31:0] n_ear1;
    logic signed [63:0] g_t, g_c, gk_t, gel64;
    logic signed [31:0] gel32;
    logic signed [63:0] y3_t, c3_t, num64, kq_t;
    logic [19:0]        n_sq;
    logic signed [20:0] num;
    logic [19:0]        mag;
    logic signed [20:0] r_t, r_sig;
    logic signed [18:0] q_s;
    logic               is_erf2, is_erf3;
    aau_pkg::t_div_res  n_div [1:aau_pkg::DIV_STAGES];

    always_comb begin
        a_in   = $signed(i_operand_a);
        b_in   = $signed(i_operand_b);
        x_half = (a_in + $signed({31'b0, a_in[31]})) >>> 1;
        xs     = (i_operation == aau_pkg::OP_SIGM) ? x_half : a_in;
        lim    = (i_operation == aau_pkg::OP_ERF) ? aau_pkg::ELIM : aau_pkg::TLIM;
        if (xs > lim) begin
            n_y = lim;
        end else if (xs < -lim) begin
            n_y = -lim;
        end else begin
            n_y = xs;
        end
        n_ear1 = (i_operation == aau_pkg::OP_MAX) ? ((a_in > b_in) ? a_in : b_in) : 32'sd0;

        g_t = aau_pkg::trunc16(64'(r_gm1)) + 64'(aau_pkg::G2);
        if (g_t < 64'sd0) begin
            g_c = 64'sd0;
        end else if (g_t > 64'(aau_pkg::GMAX)) begin
            g_c = 64'(aau_pkg::GMAX);
        end else begin
            g_c = g_t;
        end

        is_erf2 = (r_op[2] == aau_pkg::OP_ERF);
        n_sq    = 20'(r_y2p2 >>> 16);

        is_erf3 = (r_op[3] == aau_pkg::OP_ERF);
        gk_t    = aau_pkg::trunc16(64'(r_tp3));
        y3_t    = aau_pkg::trunc16(64'(r_y3p3));

        gel64 = aau_pkg::trunc16(64'(r_gkp4)) + 64'(aau_pkg::GB);
        if (gel64 > 64'sd2147483647) begin
            gel32 = 32'sh7fffffff;
        end else if (gel64 < -64'sd2147483648) begin
            gel32 = 32'sh80000000;
        end else begin
            gel32 = 32'(gel64);
        end
        c3_t  = aau_pkg::trunc16(64'(r_c3p4));
        num64 = 64'(r_y4) + c3_t;
        num   = 21'(num64);
        mag   = num[20] ? 20'(-num) : 20'(num);

        for (int j = 1; j <= aau_pkg::DIV_STAGES; j++) begin
            n_div[j] = aau_pkg::div_step(r_rem[j-1], r_low[j-1][17:15], r_den[j-1]);
        end

        q_s   = r_sgn[aau_pkg::DIV_STAGES] ? -$signed({1'b0, r_quo[aau_pkg::DIV_STAGES]})
                                           : $signed({1'b0, r_quo[aau_pkg::DIV_STAGES]});

        kq_t  = aau_pkg::trunc16(64'(r_kp));
        r_t   = 21'(kq_t);
        r_sig = aau_pkg::HALF + ((r_t + $signed({20'b0, r_t[20]})) >>> 1);
    end

    always_ff @(posedge i_clk) begin
        if (en[1]) begin
            r_op[1]  <= i_operation;
            r_ear[1] <= n_ear1;
            r_a1     <= a_in;
            r_y1     <= 19'(n_y);
            r_gm1    <= 48'(a_in) * 48'(aau_pkg::G1);
        end
        if (en[2]) begin
            r_op[2]  <= r_op[1];
            r_ear[2] <= r_ear[1];
            r_a2     <= r_a1;
            r_y2     <= r_y1;
            r_g2     <= 18'(g_c);
            r_y2p2   <= 38'(r_y1) * 38'(r_y1);
        end
        if (en[3]) begin
            r_op[3]  <= r_op[2];
            r_ear[3] <= r_ear[2];
            r_y3     <= r_y2;
            r_tp3    <= 50'(r_a2) * 50'(r_g2);
            r_y3p3   <= 40'($signed({1'b0, n_sq})) * 40'(r_y2);
            r_dp3    <= 36'(n_sq) * 36'(is_erf2 ? aau_pkg::EB2 : aau_pkg::TB2);
        end
        if (en[4]) begin
            r_op[4]  <= r_op[3];
            r_ear[4] <= r_ear[3];
            r_y4     <= r_y3;
            r_gkp4   <= 52'(gk_t) * 52'(aau_pkg::GK);
            r_c3p4   <= 38'(y3_t) * 38'(is_erf3 ? aau_pkg::E3 : aau_pkg::T3);
            r_den4   <= 19'(is_erf3 ? aau_pkg::EB0 : aau_pkg::TB0) + 19'(r_dp3 >> 16);
        end
        if (en[DIV0]) begin
            r_op[DIV0]  <= r_op[4];
            r_ear[DIV0] <= (r_op[4] == aau_pkg::OP_GELU) ? gel32 : r_ear[4];
            r_rem[0]    <= {1'b0, mag[19:2]};
            r_low[0]    <= {mag[1:0], 16'b0};
            r_quo[0]    <= '0;
            r_den[0]    <= r_den4;
            r_sgn[0]    <= num[20];
        end
        for (int j = 1; j <= aau_pkg::DIV_STAGES; j++) begin
            if (en[DIV0+j]) begin
                r_op[DIV0+j]  <= r_op[DIV0+j-1];
                r_ear[DIV0+j] <= r_ear[DIV0+j-1];
                r_rem[j] <= n_div[j].rem;
                r_quo[j] <= {r_quo[j-1][aau_pkg::QUO_W-4:0], n_div[j].quo};
                r_low[j] <= {r_low[j-1][14:0], 3'b000};
                r_den[j] <= r_den[j-1];
                r_sgn[j] <= r_sgn[j-1];
            end
        end
        if (en[NSTG-1]) begin
            r_op[NSTG-1]  <= r_op[NSTG-2];
            r_ear[NSTG-1] <= r_ear[NSTG-2];
            r_kp <= 38'(q_s) * 38'((r_op[NSTG-2] == aau_pkg::OP_ERF) ? aau_pkg::EK
                                                                     : aau_pkg::TK);
        end
        if (en[NSTG]) begin
            r_op[NSTG]  <= r_op[NSTG-1];
            r_ear[NSTG] <= r_ear[NSTG-1];
            case (r_op[NSTG-1]) inside
                aau_pkg::OP_ERF, aau_pkg::OP_TANH: r_res <= 32'(r_t);
                aau_pkg::OP_SIGM:                  r_res <= 32'(r_sig);
                default:                           r_res <= r_ear[NSTG-1];
            endcase
        end
    end

endmodule

`default_nettype wire
